@@ hw/rtl/tcpid_pkg.sv @@
package tcpid_pkg;

    // Datapath sizing
    localparam int CHANNELS           = 3;
    localparam int ERROR_WIDTH        = 16;
    localparam int GAIN_FRACTION_BITS = 8;

    localparam int GAIN_W  = 16;
    localparam int POWER_W = 16;
    localparam int INTEG_W = 32;
    localparam int DRIVE_W = 24;

    // Product of a gain and an error
    localparam int PROD_W  = ERROR_WIDTH + GAIN_W;
    // Error difference and its product
    localparam int DIFF_W  = ERROR_WIDTH + 1;
    localparam int DPROD_W = DIFF_W + GAIN_W;
    // Integrator clamp arithmetic
    localparam int BOUND_W = ((POWER_W + GAIN_FRACTION_BITS) > PROD_W ?
                              (POWER_W + GAIN_FRACTION_BITS) : PROD_W) + 1;
    localparam int ACC_W   = (INTEG_W > PROD_W ? INTEG_W : PROD_W) + 1;
    localparam int CLAMP_W = (BOUND_W > ACC_W ? BOUND_W : ACC_W) + 1;
    // Final sum of the three terms
    localparam int SUM_W   = ((INTEG_W > PROD_W ? INTEG_W : PROD_W) > DPROD_W ?
                              (INTEG_W > PROD_W ? INTEG_W : PROD_W) : DPROD_W) + 2;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // Configuration register map
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_POWER_MAX = 3'd4,
        REG_POWER_MIN = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                      enable;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic signed [POWER_W-1:0] power_max;
        logic signed [POWER_W-1:0] power_min;
    } t_cfg;

    // Terms handed from a lane to the merge stage
    typedef struct packed {
        logic signed [PROD_W-1:0]  p;
        logic signed [INTEG_W-1:0] i;
        logic signed [DPROD_W-1:0] d;
    } t_terms;

    typedef struct packed {
        logic signed [ERROR_WIDTH-1:0] error_a;
        logic signed [ERROR_WIDTH-1:0] error_b;
        logic signed [ERROR_WIDTH-1:0] error_c;
    } t_in_beat;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_a;
        logic signed [DRIVE_W-1:0] drive_b;
        logic signed [DRIVE_W-1:0] drive_c;
    } t_out_beat;

endpackage

@@ hw/rtl/three_channel_pid_antiwindup.sv @@
// Three-channel PID speed controller with integrator clamp. Each input beat
// carries one signed error per motor; three lanes run side by side and the
// merge stage sums P, I and D per lane, floors the Q8.8 fraction and saturates
// each drive to 24 bits. One beat is taken every clock unless the output
// stalls; a result passes the lane register, then the output register.
// The rate is set by the per-lane integrator update (multiply, add, clamp),
// which must finish in the accept cycle because the next beat uses it.
// Configuration indices: 0 enable, 1 gain_p, 2 gain_i, 3 gain_d, 4 power_max,
// 5 power_min; other indices are ignored. Write configuration only while idle.
// With enable low every accepted beat clears the state and gives zero drives.
module three_channel_pid_antiwindup (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tcpid_pkg::t_in_beat                  i_in_beat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tcpid_pkg::t_out_beat                 o_out_beat,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tcpid_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tcpid_pkg::*;

    t_cfg   r_cfg;
    logic   r_s1_valid;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_s1_move;
    logic   w_in_take;
    logic signed [ERROR_WIDTH-1:0] w_error [CHANNELS];
    t_terms w_terms [CHANNELS];

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.gain_p    <= GAIN_W'(256);
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.power_max <= POWER_W'(100);
            r_cfg.power_min <= -POWER_W'(100);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ENABLE:    r_cfg.enable    <= i_cfg_data[0];
                REG_GAIN_P:    r_cfg.gain_p    <= i_cfg_data;
                REG_GAIN_I:    r_cfg.gain_i    <= i_cfg_data;
                REG_GAIN_D:    r_cfg.gain_d    <= i_cfg_data;
                REG_POWER_MAX: r_cfg.power_max <= $signed(i_cfg_data);
                REG_POWER_MIN: r_cfg.power_min <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: lane stage, then output register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= w_in_take || (r_s1_valid && !w_s1_move);
            r_out_valid <= w_s1_move || (r_out_valid && !i_out_ready);
        end
    end

    assign o_out_valid = r_out_valid;

    // Spread the beat across the lanes
    assign w_error[0] = i_in_beat.error_a;
    assign w_error[1] = i_in_beat.error_b;
    assign w_error[2] = i_in_beat.error_c;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        tcpid_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_in_take),
            .i_cfg   (r_cfg),
            .i_error (w_error[g]),
            .o_terms (w_terms[g])
        );
    end

    tcpid_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (w_s1_move),
        .i_terms (w_terms),
        .o_beat  (o_out_beat)
    );

    // Checks
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are held");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_valid)
        else $error("accepted beat did not reach the lane stage");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a beat in the lane stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule

@@ hw/rtl/tcpid_lane.sv @@
module tcpid_lane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  tcpid_pkg::t_cfg                        i_cfg,
    input  logic signed [tcpid_pkg::ERROR_WIDTH-1:0] i_error,
    output tcpid_pkg::t_terms                      o_terms
);
    import tcpid_pkg::*;

    logic signed [ERROR_WIDTH-1:0] r_prev;
    logic signed [INTEG_W-1:0]     r_integ;
    t_terms                        r_terms;

    logic signed [PROD_W-1:0]  w_p;
    logic signed [PROD_W-1:0]  w_ip;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DPROD_W-1:0] w_dp;
    logic signed [CLAMP_W-1:0] w_hi;
    logic signed [CLAMP_W-1:0] w_lo;
    logic signed [CLAMP_W-1:0] w_acc;
    logic signed [CLAMP_W-1:0] w_clip;
    logic signed [INTEG_W-1:0] n_integ;
    logic                      w_integ_on;

    // Products of the gains with the error and its difference
    assign w_p    = PROD_W'($signed({1'b0, i_cfg.gain_p})) * PROD_W'(i_error);
    assign w_ip   = PROD_W'($signed({1'b0, i_cfg.gain_i})) * PROD_W'(i_error);
    assign w_diff = DIFF_W'(i_error) - DIFF_W'(r_prev);
    assign w_dp   = DPROD_W'($signed({1'b0, i_cfg.gain_d})) * DPROD_W'(w_diff);

    // Bounds on the integral that keep P + I inside the power limits
    assign w_hi  = (CLAMP_W'(i_cfg.power_max) <<< GAIN_FRACTION_BITS) - CLAMP_W'(w_p);
    assign w_lo  = (CLAMP_W'(i_cfg.power_min) <<< GAIN_FRACTION_BITS) - CLAMP_W'(w_p);
    assign w_acc = CLAMP_W'(r_integ) + CLAMP_W'(w_ip);

    assign w_integ_on = (i_cfg.gain_i != '0);

    // Clamp upper first, then lower, then to the integrator width
    always_comb begin
        w_clip = w_acc;
        if (w_clip > w_hi) begin
            w_clip = w_hi;
        end
        if (w_clip < w_lo) begin
            w_clip = w_lo;
        end
        if (w_clip > CLAMP_W'(INTEG_MAX)) begin
            w_clip = CLAMP_W'(INTEG_MAX);
        end
        if (w_clip < CLAMP_W'(INTEG_MIN)) begin
            w_clip = CLAMP_W'(INTEG_MIN);
        end
        n_integ = INTEG_W'(w_clip);
    end

    // Update the channel state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
        end else if (i_load) begin
            if (!i_cfg.enable) begin
                r_prev  <= '0;
                r_integ <= '0;
            end else begin
                r_prev <= i_error;
                if (w_integ_on) begin
                    r_integ <= n_integ;
                end
            end
        end
    end

    // Hold the terms for the merge stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (!i_cfg.enable) begin
                r_terms <= '0;
            end else begin
                r_terms.p <= w_p;
                r_terms.i <= w_integ_on ? n_integ : '0;
                r_terms.d <= w_dp;
            end
        end
    end

    assign o_terms = r_terms;

endmodule

@@ hw/rtl/tcpid_merge.sv @@
module tcpid_merge (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  tcpid_pkg::t_terms    i_terms [tcpid_pkg::CHANNELS],
    output tcpid_pkg::t_out_beat o_beat
);
    import tcpid_pkg::*;

    logic signed [DRIVE_W-1:0] r_drive [CHANNELS];
    logic signed [DRIVE_W-1:0] n_drive [CHANNELS];
    logic signed [SUM_W-1:0]   w_sum   [CHANNELS];
    logic signed [SUM_W-1:0]   w_shift [CHANNELS];

    // Add the terms of each lane, floor the fraction, saturate
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_sum[c]   = SUM_W'(i_terms[c].p) + SUM_W'(i_terms[c].i)
                       + SUM_W'(i_terms[c].d);
            w_shift[c] = w_sum[c] >>> GAIN_FRACTION_BITS;
            if (w_shift[c] > SUM_W'(DRIVE_MAX)) begin
                n_drive[c] = DRIVE_MAX;
            end else if (w_shift[c] < SUM_W'(DRIVE_MIN)) begin
                n_drive[c] = DRIVE_MIN;
            end else begin
                n_drive[c] = DRIVE_W'(w_shift[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
        end
    end

    assign o_beat.drive_a = r_drive[0];
    assign o_beat.drive_b = r_drive[1];
    assign o_beat.drive_c = r_drive[2];

endmodule
